// ===== hw/rtl/swr_pkg.sv =====
// ----------------------------------------------------------------------------
// swr_pkg: shared types and constants for the square window rotator
// Word layouts of both channels, opcodes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package swr_pkg;

  // Default largest matrix side
  localparam int unsigned MaxSideDefault = 64;

  // Field widths
  localparam int unsigned SizeW   = 7;
  localparam int unsigned ValueW  = 13;
  localparam int unsigned CoordW  = 6;
  localparam int unsigned RadiusW = 5;
  localparam int unsigned OpW     = 2;

  // Opcodes
  localparam logic [OpW-1:0] OpInit   = 2'd0;
  localparam logic [OpW-1:0] OpRotate = 2'd1;
  localparam logic [OpW-1:0] OpRead   = 2'd2;

  // Input word
  typedef struct packed {
    logic [OpW-1:0]     opcode;
    logic [CoordW-1:0]  row;
    logic [CoordW-1:0]  column;
    logic [RadiusW-1:0] radius;
    logic               direction;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic              status;
    logic [ValueW-1:0] element_value;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/square_window_rotator_core.sv =====
// ----------------------------------------------------------------------------
// square_window_rotator_core: square matrix with window rotation
// Holds the matrix in a synchronous memory; rotates a square window by
// 90 degrees through a second window buffer memory, fills row-major, reads.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+---------------------
//  in      | input     | in_valid_i / in_ready_o  | in_word_i (in_word_t)
//  out     | output    | out_valid_o / out_ready_i| out_word_o (out_word_t)
//  cfg     | input     | cfg_we_i, no wait        | cfg_data_i (side size)
//
//  One word at a time. Rotate with n = 2*radius+1 makes n*n reads of the
//  store into the buffer, then n*n reads of the buffer back into the store,
//  both limited by one access per memory port a cycle. Init writes the
//  store with one store write a cycle. After reset a fill pass over the
//  top-left min(64, side cap) square loads the start values with
//  in_ready_o low. The finished result sits in an output register; a
//  stalled output holds the next word in its finish state until the
//  register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module square_window_rotator_core #(
  parameter int unsigned MAX_SIDE = swr_pkg::MaxSideDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  swr_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output swr_pkg::out_word_t             out_word_o,
  input  logic                           cfg_we_i,
  input  logic [swr_pkg::SizeW-1:0]      cfg_data_i
);

  import swr_pkg::*;

  // Derived sizes
  localparam int unsigned SizeMax    = (1 << SizeW) - 1;
  localparam int unsigned SideCap    = (MAX_SIDE > SizeMax) ? SizeMax : MAX_SIDE;
  localparam int unsigned ResetSide  = (SideCap < 64) ? SideCap : 64;
  localparam int unsigned CW         = (SideCap > 1) ? $clog2(SideCap) : 1;
  localparam int unsigned AW         = 2 * CW;
  localparam int unsigned StoreDepth = 1 << AW;
  localparam int unsigned BufAW      = 2 * CoordW;
  localparam int unsigned BufDepth   = 1 << BufAW;

  localparam logic [SizeW-1:0] SideCapV   = SizeW'(SideCap);
  localparam logic [SizeW-1:0] ResetSideV = SizeW'(ResetSide);
  localparam logic [SizeW-1:0] SizeReset  = SizeW'(64);

  // Sequencer states
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StFill   = 3'd1;
  localparam logic [2:0] StCopy   = 3'd2;
  localparam logic [2:0] StGap    = 3'd3;
  localparam logic [2:0] StPlace  = 3'd4;
  localparam logic [2:0] StRead   = 3'd5;
  localparam logic [2:0] StFinish = 3'd6;

  // Control registers
  logic [2:0]         state_q, state_d;
  logic [SizeW-1:0]   size_q, size_d;
  logic               out_valid_q, out_valid_d;
  logic               clr_q, clr_d;          // fill pass is the post-reset load
  logic               cp_wr_q, cp_wr_d;      // buffer write pending
  logic               pl_wr_q, pl_wr_d;      // store write pending
  logic [CW-1:0]      fr_q, fr_d, fc_q, fc_d;
  logic [ValueW-1:0]  fv_q, fv_d;
  logic [SizeW-1:0]   fill_side_q, fill_side_d;
  logic [CoordW-1:0]  a_q, a_d, b_q, b_d;

  // Word and address registers
  logic [OpW-1:0]     op_q, op_d;
  logic [CoordW-1:0]  row_q, row_d, col_q, col_d;
  logic [CoordW-1:0]  r0_q, r0_d, c0_q, c0_d, n1_q, n1_d;
  logic               dir_q, dir_d;
  logic               st_q, st_d;
  logic [BufAW-1:0]   cp_addr_q, cp_addr_d;
  logic [AW-1:0]      pl_addr_q, pl_addr_d;
  out_word_t          out_q, out_d;

  // Memory ports
  logic               store_we, store_re;
  logic [AW-1:0]      store_waddr, store_raddr;
  logic [ValueW-1:0]  store_wdata, store_rdata_q;
  logic               buf_we, buf_re;
  logic [BufAW-1:0]   buf_waddr, buf_raddr;
  logic [ValueW-1:0]  buf_wdata, buf_rdata_q;

  logic [ValueW-1:0]  store_mem [StoreDepth];
  logic [ValueW-1:0]  win_mem [BufDepth];

  // Helpers
  logic [SizeW-1:0]   side;
  logic [SizeW-1:0]   row_ext, col_ext, rad_ext, row_hi, col_hi;
  logic               bad_win, bad_cell;
  logic [SizeW-1:0]   win_r, win_c;
  logic [AW-1:0]      win_addr;
  logic               win_last, fill_col_last, fill_row_last, out_free;
  logic [CoordW-1:0]  src_r, src_c;

  // Side in use, clamped to 1..cap
  always_comb begin
    if (size_q == '0) begin
      side = SizeW'(1);
    end else if (size_q > SideCapV) begin
      side = SideCapV;
    end else begin
      side = size_q;
    end
  end

  // Range checks on the incoming word
  assign row_ext  = SizeW'(in_word_i.row);
  assign col_ext  = SizeW'(in_word_i.column);
  assign rad_ext  = SizeW'(in_word_i.radius);
  assign row_hi   = row_ext + rad_ext;
  assign col_hi   = col_ext + rad_ext;
  assign bad_win  = (row_ext < rad_ext) || (col_ext < rad_ext) ||
                    (row_hi >= side) || (col_hi >= side);
  assign bad_cell = (row_ext >= side) || (col_ext >= side);

  // Window cell address in the store
  assign win_r    = SizeW'(r0_q) + SizeW'(a_q);
  assign win_c    = SizeW'(c0_q) + SizeW'(b_q);
  assign win_addr = {CW'(win_r), CW'(win_c)};
  assign win_last = (a_q == n1_q) && (b_q == n1_q);

  // Source cell in the buffer for the turned window
  always_comb begin
    if (!dir_q) begin
      src_r = n1_q - b_q;
      src_c = a_q;
    end else begin
      src_r = b_q;
      src_c = n1_q - a_q;
    end
  end

  assign fill_col_last = (SizeW'(fc_q) == fill_side_q - SizeW'(1));
  assign fill_row_last = (SizeW'(fr_q) == fill_side_q - SizeW'(1));
  assign out_free      = !out_valid_q || out_ready_i;

  // Memory port muxing
  assign store_we    = (state_q == StFill) || pl_wr_q;
  assign store_waddr = pl_wr_q ? pl_addr_q : {fr_q, fc_q};
  assign store_wdata = pl_wr_q ? buf_rdata_q : fv_q;
  assign store_re    = (state_q == StCopy) || (state_q == StRead);
  assign store_raddr = (state_q == StRead) ? {CW'(row_q), CW'(col_q)} : win_addr;
  assign buf_we      = cp_wr_q;
  assign buf_waddr   = cp_addr_q;
  assign buf_wdata   = store_rdata_q;
  assign buf_re      = (state_q == StPlace);
  assign buf_raddr   = {src_r, src_c};

  // Sequencer
  always_comb begin
    state_d     = state_q;
    size_d      = cfg_we_i ? cfg_data_i : size_q;
    clr_d       = clr_q;
    cp_wr_d     = (state_q == StCopy);
    pl_wr_d     = (state_q == StPlace);
    fr_d        = fr_q;
    fc_d        = fc_q;
    fv_d        = fv_q;
    fill_side_d = fill_side_q;
    a_d         = a_q;
    b_d         = b_q;
    op_d        = op_q;
    row_d       = row_q;
    col_d       = col_q;
    r0_d        = r0_q;
    c0_d        = c0_q;
    n1_d        = n1_q;
    dir_d       = dir_q;
    st_d        = st_q;
    cp_addr_d   = {a_q, b_q};
    pl_addr_d   = win_addr;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          op_d  = in_word_i.opcode;
          row_d = in_word_i.row;
          col_d = in_word_i.column;
          dir_d = in_word_i.direction;
          r0_d  = in_word_i.row - CoordW'(in_word_i.radius);
          c0_d  = in_word_i.column - CoordW'(in_word_i.radius);
          n1_d  = {in_word_i.radius, 1'b0};
          a_d   = '0;
          b_d   = '0;
          st_d  = 1'b0;
          unique case (in_word_i.opcode)
            OpInit: begin
              fr_d        = '0;
              fc_d        = '0;
              fv_d        = ValueW'(1);
              fill_side_d = side;
              state_d     = StFill;
            end
            OpRotate: begin
              st_d    = bad_win;
              state_d = bad_win ? StFinish : StCopy;
            end
            OpRead: begin
              st_d    = bad_cell;
              state_d = bad_cell ? StFinish : StRead;
            end
            default: begin
              st_d    = 1'b1;
              state_d = StFinish;
            end
          endcase
        end
      end
      StFill: begin
        fv_d = fv_q + ValueW'(1);
        if (fill_col_last) begin
          fc_d = '0;
          fr_d = fr_q + CW'(1);
          if (fill_row_last) begin
            clr_d   = 1'b0;
            state_d = clr_q ? StIdle : StFinish;
          end
        end else begin
          fc_d = fc_q + CW'(1);
        end
      end
      StCopy, StPlace: begin
        if (b_q == n1_q) begin
          b_d = '0;
          a_d = a_q + CoordW'(1);
        end else begin
          b_d = b_q + CoordW'(1);
        end
        if (win_last) begin
          a_d     = '0;
          b_d     = '0;
          state_d = (state_q == StCopy) ? StGap : StFinish;
        end
      end
      StGap: begin
        state_d = StPlace;
      end
      StRead: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (out_free) begin
          out_d.status        = st_q;
          out_d.element_value = ((op_q == OpRead) && !st_q) ? store_rdata_q : '0;
          out_valid_d         = 1'b1;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers; reset starts the load of the start values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StFill;
      size_q      <= SizeReset;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      cp_wr_q     <= 1'b0;
      pl_wr_q     <= 1'b0;
      fr_q        <= '0;
      fc_q        <= '0;
      fv_q        <= ValueW'(1);
      fill_side_q <= ResetSideV;
      a_q         <= '0;
      b_q         <= '0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      cp_wr_q     <= cp_wr_d;
      pl_wr_q     <= pl_wr_d;
      fr_q        <= fr_d;
      fc_q        <= fc_d;
      fv_q        <= fv_d;
      fill_side_q <= fill_side_d;
      a_q         <= a_d;
      b_q         <= b_d;
    end
  end

  // Word and address registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    row_q     <= row_d;
    col_q     <= col_d;
    r0_q      <= r0_d;
    c0_q      <= c0_d;
    n1_q      <= n1_d;
    dir_q     <= dir_d;
    st_q      <= st_d;
    cp_addr_q <= cp_addr_d;
    pl_addr_q <= pl_addr_d;
    out_q     <= out_d;
  end

  // Matrix store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    if (store_re) begin
      store_rdata_q <= store_mem[store_raddr];
    end
  end

  // Window buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      win_mem[buf_waddr] <= buf_wdata;
    end
    if (buf_re) begin
      buf_rdata_q <= win_mem[buf_raddr];
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Checks
  a_store_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (store_re && store_we) |-> (store_raddr != store_waddr))
    else $error("store read and write hit the same cell");

  a_buf_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_re && buf_we) |-> (buf_raddr != buf_waddr))
    else $error("buffer read and write hit the same cell");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!pl_wr_q && !cp_wr_q))
    else $error("new word taken with a write still pending");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && out_free) |=> out_valid_o)
    else $error("finished word did not reach the output");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for square_window_rotator_core
// Drives init, rotate, read and unknown words through the valid/ready input
// channel with random gaps and output stalls. Each word is checked against an
// internal matrix model. Several matrix sides from 0 to 127 are set between phases.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import swr_pkg::*;

  localparam logic [OpW-1:0] OpUnknown = 2'd3;
  localparam int unsigned    SettleCycles = 8;
  localparam int unsigned    PhaseWords   = 9;

  // Matrix model with a queue of expected result words
  class window_scoreboard;
    logic [ValueW-1:0] grid [MaxSideDefault][MaxSideDefault];
    logic [SizeW-1:0]  size_reg;
    out_word_t         expected_q[$];
    int unsigned       error_count;

    function new();
      foreach (grid[r, c]) grid[r][c] = '0;
      size_reg    = SizeW'(MaxSideDefault);
      error_count = 0;
      fill();
    endfunction

    // register value clamped into 1..MaxSideDefault
    function int unsigned side();
      if (size_reg == 0) return 1;
      if (size_reg > MaxSideDefault) return MaxSideDefault;
      return size_reg;
    endfunction

    // row-major count, cells outside the square keep their values
    function void fill();
      int unsigned s;
      s = side();
      for (int unsigned r = 0; r < s; r++)
        for (int unsigned c = 0; c < s; c++)
          grid[r][c] = ValueW'(r * s + c + 1);
    endfunction

    function void set_size(logic [SizeW-1:0] v);
      size_reg = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // turn the n by n window at (r0, c0) by a quarter
    function void turn_window(int unsigned r0, int unsigned c0, int unsigned n,
                              logic ccw);
      logic [ValueW-1:0] win [63][63];
      for (int unsigned a = 0; a < n; a++)
        for (int unsigned b = 0; b < n; b++)
          win[a][b] = grid[r0 + a][c0 + b];
      for (int unsigned a = 0; a < n; a++)
        for (int unsigned b = 0; b < n; b++)
          grid[r0 + a][c0 + b] = ccw ? win[b][n - 1 - a] : win[n - 1 - b][a];
    endfunction

    // apply one accepted input word and queue its result
    function void note_input(in_word_t w);
      out_word_t   res;
      int unsigned s, rw, cl, rd;
      s  = side();
      rw = w.row;
      cl = w.column;
      rd = w.radius;
      res.status        = 1'b0;
      res.element_value = '0;
      case (w.opcode)
        OpInit: begin
          fill();
        end
        OpRotate: begin
          if (rw < rd || cl < rd || rw + rd >= s || cl + rd >= s)
            res.status = 1'b1;
          else
            turn_window(rw - rd, cl - rd, 2 * rd + 1, w.direction);
        end
        OpRead: begin
          if (rw >= s || cl >= s)
            res.status = 1'b1;
          else
            res.element_value = grid[rw][cl];
        end
        default: begin
          res.status = 1'b1;
        end
      endcase
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got,
               want);
      error_count++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("word with none outstanding", got, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.element_value !== want.element_value)
        report_mismatch("element_value", got.element_value, want.element_value);
    endtask
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  in_word_t           in_word_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_word_t          out_word_o;
  logic               cfg_we_i    = 1'b0;
  logic [SizeW-1:0]   cfg_data_i  = '0;

  int unsigned        in_idle_pct  = 30;
  int unsigned        out_idle_pct = 30;

  window_scoreboard   sb = new();

  always #2 clk_i = ~clk_i;

  square_window_rotator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Result side: check accepted words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_word_o);
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic in_word_t make_word(logic [OpW-1:0] op, int unsigned rw,
                                         int unsigned cl, int unsigned rd,
                                         logic dir);
    in_word_t w;
    w.opcode    = op;
    w.row       = CoordW'(rw);
    w.column    = CoordW'(cl);
    w.radius    = RadiusW'(rd);
    w.direction = dir;
    return w;
  endfunction

  // mostly well-formed words for the current side, some raw noise
  function automatic in_word_t random_word(int unsigned s);
    int unsigned pick, max_rad, rd;
    pick = $urandom_range(99);
    if (pick < 5)
      return make_word(OpInit, $urandom_range(63), $urandom_range(63),
                       $urandom_range(31), 1'($urandom_range(1)));
    if (pick < 50) begin
      max_rad = (s - 1) / 2;
      if ($urandom_range(99) < 85)
        rd = $urandom_range(0, (max_rad < 3) ? max_rad : 3);
      else
        rd = $urandom_range(0, max_rad);
      return make_word(OpRotate, $urandom_range(rd, s - 1 - rd),
                       $urandom_range(rd, s - 1 - rd), rd, 1'($urandom_range(1)));
    end
    if (pick < 85)
      return make_word(OpRead, $urandom_range(0, s - 1), $urandom_range(0, s - 1),
                       $urandom_range(31), 1'($urandom_range(1)));
    return make_word(OpW'($urandom_range(3)), $urandom_range(63),
                     $urandom_range(63), $urandom_range(31), 1'($urandom_range(1)));
  endfunction

  // hand one word to the block; valid stays up unless a gap is taken
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(w);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_size(logic [SizeW-1:0] v);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_size(v);
    cfg_we_i   <= 1'b0;
  endtask

  // Timeout guard
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [SizeW-1:0] phase_size [8];

    phase_size = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd9, 7'd100, 7'd2, 7'd0};
    phase_size[7] = SizeW'($urandom_range(3, 63));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners of the reset fill
    send_word(make_word(OpRead, 0, 0, 0, 1'b0));
    send_word(make_word(OpRead, 63, 63, 31, 1'b1));
    send_word(make_word(OpRead, 63, 0, 0, 1'b0));
    // small turn both ways, radius zero, largest window both ways
    send_word(make_word(OpRotate, 1, 1, 1, 1'b0));
    send_word(make_word(OpRead, 0, 0, 0, 1'b0));
    send_word(make_word(OpRotate, 1, 1, 1, 1'b1));
    send_word(make_word(OpRead, 0, 2, 0, 1'b0));
    send_word(make_word(OpRotate, 5, 5, 0, 1'b0));
    send_word(make_word(OpRotate, 31, 31, 31, 1'b0));
    send_word(make_word(OpRead, 0, 0, 0, 1'b0));
    send_word(make_word(OpRotate, 32, 32, 31, 1'b1));
    // windows over each edge
    send_word(make_word(OpRotate, 0, 5, 1, 1'b0));
    send_word(make_word(OpRotate, 5, 0, 1, 1'b1));
    send_word(make_word(OpRotate, 62, 10, 2, 1'b0));
    send_word(make_word(OpRotate, 10, 62, 2, 1'b1));
    send_word(make_word(OpRotate, 63, 63, 31, 1'b1));
    // unknown opcode with every field at its top
    send_word(make_word(OpUnknown, 63, 63, 31, 1'b1));
    send_word(make_word(OpInit, 0, 0, 0, 1'b0));
    send_word(make_word(OpRead, 42, 21, 0, 1'b0));
    // small fill keeps the cells outside the square
    write_size(7'd5);
    send_word(make_word(OpInit, 0, 0, 0, 1'b0));
    send_word(make_word(OpRead, 4, 4, 0, 1'b0));
    send_word(make_word(OpRead, 5, 0, 0, 1'b0));
    send_word(make_word(OpRead, 0, 5, 0, 1'b0));
    write_size(7'd64);
    send_word(make_word(OpRead, 0, 5, 0, 1'b0));
    send_word(make_word(OpRead, 1, 0, 0, 1'b0));

    // random phases over several sides, one without any gaps
    foreach (phase_size[p]) begin
      write_size(phase_size[p]);
      in_idle_pct  = (p == 3) ? 0 : 30;
      out_idle_pct = (p == 3) ? 0 : 30;
      if ($urandom_range(1) == 1) send_word(make_word(OpInit, 0, 0, 0, 1'b0));
      for (int i = 0; i < PhaseWords; i++) begin
        if (p == 0 && i == 6) settle();
        send_word(random_word(sb.side()));
      end
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== square_window_rotator_core.f =====
hw/rtl/swr_pkg.sv
hw/rtl/square_window_rotator_core.sv
bench/tb_top.sv
